// ===== design/sfcs_pkg.sv =====
// Package with shared types, codes and constants of the SPI flash command sequencer.
package sfcs_pkg;

  localparam int unsigned PageBytesDef  = 256;
  localparam int unsigned EraseBytesDef = 65536;

  typedef enum logic [2:0] {
    REQ_ERASE = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_READ  = 3'd2,
    REQ_PROBE = 3'd3,
    REQ_WDATA = 3'd4,
    REQ_RXB   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ACT_TX   = 3'd0,
    ACT_RX   = 3'd1,
    ACT_REL  = 3'd2,
    ACT_HOST = 3'd3,
    ACT_DONE = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WDATA,
    PH_RDATA,
    PH_POLL,
    PH_ID
  } phase_e;

  // Result sequences that the back end expands into bus actions.
  typedef enum logic [3:0] {
    SEQ_FAULT,
    SEQ_DONE,
    SEQ_BLOCK,
    SEQ_PAGE,
    SEQ_READ_RX,
    SEQ_READ_POLL,
    SEQ_PROBE,
    SEQ_TX_ONLY,
    SEQ_TX_POLL,
    SEQ_HOST_RX,
    SEQ_HOST_POLL,
    SEQ_RX,
    SEQ_REL_BLOCK,
    SEQ_REL_PAGE,
    SEQ_REL_DONE,
    SEQ_REL_DONE_ID
  } seq_e;

  localparam logic [7:0] CmdWren  = 8'h06;
  localparam logic [7:0] CmdBe    = 8'hD8;
  localparam logic [7:0] CmdPp    = 8'h02;
  localparam logic [7:0] CmdRead  = 8'h03;
  localparam logic [7:0] CmdRdsr  = 8'h05;
  localparam logic [7:0] CmdRdid  = 8'h9F;
  localparam logic [7:0] CmdRsten = 8'h66;
  localparam logic [7:0] CmdRst   = 8'h99;
  localparam logic [7:0] CmdWrsr  = 8'h01;

  // Request payload: one erase/write/read/probe request, write data byte or flash byte.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [23:0] flash_addr;
    logic [24:0] span;
    logic [7:0]  data_byte;
  } req_t;

  // Result payload: one SPI bus action.
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  bus_byte;
    logic [23:0] device_id;
    logic        fault;
    logic        last;
  } res_t;

  // One classified request handed from front to back.
  typedef struct packed {
    seq_e        seq;
    logic [23:0] addr;
    logic [7:0]  data;
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

endpackage

// ===== design/sfcs_if.sv =====
// Valid/ready channel interface carrying one payload.
interface sfcs_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sfcs_front.sv =====
// Front end: tracks the operation state and classifies each input item into a job.
module sfcs_front #(
  parameter int unsigned PageBytes  = sfcs_pkg::PageBytesDef,
  parameter int unsigned EraseBytes = sfcs_pkg::EraseBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        req_type_i,
  input  logic [23:0]       flash_addr_i,
  input  logic [24:0]       span_i,
  input  logic [7:0]        data_byte_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output sfcs_pkg::job_t    job_o
);
  localparam int unsigned PgW = $clog2(PageBytes);
  localparam int unsigned EbW = $clog2(EraseBytes);
  localparam int unsigned BlkW = 25 - EbW;

  sfcs_pkg::phase_e  phase_q, phase_d;
  logic [1:0]        op_q, op_d;
  logic [23:0]       addr_q, addr_d;
  logic [24:0]       rem_q, rem_d;
  logic [PgW:0]      page_q, page_d;
  logic [BlkW-1:0]   blk_q, blk_d;
  logic [23:0]       id_q, id_d;
  logic [1:0]        idx_q, idx_d;

  logic              acc;
  logic [24:0]       diff;
  logic [PgW:0]      room;
  logic [PgW:0]      room_take;
  logic [23:0]       id_new;
  logic [23:0]       next_blk_addr;
  sfcs_pkg::job_t    job;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign job_o       = job;
  assign acc         = in_valid_i && job_ready_i;

  assign diff = span_i - {1'b0, flash_addr_i};
  assign next_blk_addr = addr_q + 24'(EraseBytes);

  always_comb begin
    room = (PgW+1)'(PageBytes) - {1'b0, addr_q[PgW-1:0]};
    room_take = (rem_q < 25'(room)) ? rem_q[PgW:0] : room;
  end

  always_comb begin
    id_new = id_q;
    unique case (idx_q)
      2'd0:    id_new[7:0]   = data_byte_i;
      2'd1:    id_new[15:8]  = data_byte_i;
      2'd2:    id_new[23:16] = data_byte_i;
      default: id_new        = id_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    page_d  = page_q;
    blk_d   = blk_q;
    id_d    = id_q;
    idx_d   = idx_q;
    job.seq  = sfcs_pkg::SEQ_FAULT;
    job.addr = addr_q;
    job.data = data_byte_i;
    priority if (phase_q == sfcs_pkg::PH_IDLE && req_type_i <= sfcs_pkg::REQ_PROBE) begin
      op_d   = req_type_i[1:0];
      addr_d = flash_addr_i;
      job.addr = flash_addr_i;
      unique case (req_type_i)
        sfcs_pkg::REQ_ERASE: begin
          blk_d = (span_i > {1'b0, flash_addr_i}) ? diff[24:EbW] : '0;
          if (span_i > {1'b0, flash_addr_i} && diff[24:EbW] != '0) begin
            job.seq = sfcs_pkg::SEQ_BLOCK;
            phase_d = sfcs_pkg::PH_POLL;
          end else begin
            job.seq = sfcs_pkg::SEQ_DONE;
          end
        end
        sfcs_pkg::REQ_WRITE: begin
          rem_d = span_i;
          if (span_i != '0) begin
            job.seq = sfcs_pkg::SEQ_PAGE;
            phase_d = sfcs_pkg::PH_WDATA;
            page_d  = ((span_i < 25'(PageBytes - flash_addr_i[PgW-1:0])) ?
                       span_i[PgW:0] :
                       (PgW+1)'(PageBytes) - {1'b0, flash_addr_i[PgW-1:0]});
          end else begin
            job.seq = sfcs_pkg::SEQ_DONE;
          end
        end
        sfcs_pkg::REQ_READ: begin
          rem_d = span_i;
          if (span_i != '0) begin
            job.seq = sfcs_pkg::SEQ_READ_RX;
            phase_d = sfcs_pkg::PH_RDATA;
          end else begin
            job.seq = sfcs_pkg::SEQ_READ_POLL;
            phase_d = sfcs_pkg::PH_POLL;
          end
        end
        default: begin
          id_d    = '0;
          idx_d   = '0;
          job.seq = sfcs_pkg::SEQ_PROBE;
          phase_d = sfcs_pkg::PH_ID;
        end
      endcase
    end else if (phase_q == sfcs_pkg::PH_WDATA && req_type_i == sfcs_pkg::REQ_WDATA) begin
      addr_d = addr_q + 24'd1;
      rem_d  = rem_q - 25'd1;
      page_d = page_q - 1'b1;
      if (page_q == (PgW+1)'(1)) begin
        job.seq = sfcs_pkg::SEQ_TX_POLL;
        phase_d = sfcs_pkg::PH_POLL;
      end else begin
        job.seq = sfcs_pkg::SEQ_TX_ONLY;
      end
    end else if (phase_q == sfcs_pkg::PH_RDATA && req_type_i == sfcs_pkg::REQ_RXB) begin
      rem_d = rem_q - 25'd1;
      if (rem_q != 25'd1) begin
        job.seq = sfcs_pkg::SEQ_HOST_RX;
      end else begin
        job.seq = sfcs_pkg::SEQ_HOST_POLL;
        phase_d = sfcs_pkg::PH_POLL;
      end
    end else if (phase_q == sfcs_pkg::PH_POLL && req_type_i == sfcs_pkg::REQ_RXB) begin
      if (data_byte_i[0]) begin
        job.seq = sfcs_pkg::SEQ_RX;
      end else if (op_q == 2'(sfcs_pkg::REQ_ERASE)) begin
        blk_d  = blk_q - 1'b1;
        addr_d = next_blk_addr;
        job.addr = next_blk_addr;
        if (blk_q != BlkW'(1)) begin
          job.seq = sfcs_pkg::SEQ_REL_BLOCK;
        end else begin
          job.seq = sfcs_pkg::SEQ_REL_DONE;
          phase_d = sfcs_pkg::PH_IDLE;
        end
      end else if (op_q == 2'(sfcs_pkg::REQ_WRITE) && rem_q != '0) begin
        job.seq = sfcs_pkg::SEQ_REL_PAGE;
        phase_d = sfcs_pkg::PH_WDATA;
        page_d  = room_take;
      end else begin
        job.seq = sfcs_pkg::SEQ_REL_DONE;
        phase_d = sfcs_pkg::PH_IDLE;
      end
    end else if (phase_q == sfcs_pkg::PH_ID && req_type_i == sfcs_pkg::REQ_RXB) begin
      id_d  = id_new;
      idx_d = idx_q + 2'd1;
      if (idx_q == 2'd2) begin
        idx_d   = '0;
        job.seq = sfcs_pkg::SEQ_REL_DONE_ID;
        job.addr = id_new;
        phase_d = sfcs_pkg::PH_IDLE;
      end else begin
        job.seq = sfcs_pkg::SEQ_RX;
      end
    end else begin
      job.seq = sfcs_pkg::SEQ_FAULT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfcs_pkg::PH_IDLE;
      op_q    <= '0;
      addr_q  <= '0;
      rem_q   <= '0;
      page_q  <= '0;
      blk_q   <= '0;
      id_q    <= '0;
      idx_q   <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      page_q  <= page_d;
      blk_q   <= blk_d;
      id_q    <= id_d;
      idx_q   <= idx_d;
    end
  end
endmodule

// ===== design/sfcs_queue.sv =====
// Short two-entry queue of jobs between the front and back ends.
module sfcs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  sfcs_pkg::job_t wr_job_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output sfcs_pkg::job_t rd_job_o
);
  sfcs_pkg::job_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_job_o   = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ===== design/sfcs_back.sv =====
// Back end: expands each job into its bus actions, one result per cycle while results are taken.
module sfcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  sfcs_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     action_o,
  output logic [7:0]     bus_byte_o,
  output logic [23:0]    device_id_o,
  output logic           fault_o,
  output logic           last_o
);
  logic [3:0]  step_q;
  logic        vld_q;
  logic [2:0]  act_q;
  logic [7:0]  byte_q;
  logic [23:0] id_q;
  logic        flt_q, last_q;

  logic [2:0]  act;
  logic [7:0]  byt;
  logic        fin;
  logic        load;
  logic [23:0] a;

  assign a = job_i.addr;
  assign load = job_valid_i && (!vld_q || out_ready_i);
  assign job_ready_o = load && fin;

  // Action table: step number within a sequence gives one result.
  always_comb begin
    act = sfcs_pkg::ACT_TX;
    byt = 8'h00;
    fin = 1'b0;
    unique case (job_i.seq)
      sfcs_pkg::SEQ_FAULT, sfcs_pkg::SEQ_DONE: begin
        act = (job_i.seq == sfcs_pkg::SEQ_FAULT) ? sfcs_pkg::ACT_REL : sfcs_pkg::ACT_DONE;
        fin = 1'b1;
      end
      sfcs_pkg::SEQ_BLOCK, sfcs_pkg::SEQ_PAGE, sfcs_pkg::SEQ_REL_BLOCK,
      sfcs_pkg::SEQ_REL_PAGE: begin
        logic [3:0] s;
        s = step_q;
        if (job_i.seq == sfcs_pkg::SEQ_REL_BLOCK || job_i.seq == sfcs_pkg::SEQ_REL_PAGE) begin
          s = step_q - 4'd1;
        end
        if (step_q == 4'd0 &&
            (job_i.seq == sfcs_pkg::SEQ_REL_BLOCK || job_i.seq == sfcs_pkg::SEQ_REL_PAGE)) begin
          act = sfcs_pkg::ACT_REL;
        end else begin
          unique case (s)
            4'd0: byt = sfcs_pkg::CmdWren;
            4'd1: act = sfcs_pkg::ACT_REL;
            4'd2: byt = (job_i.seq == sfcs_pkg::SEQ_BLOCK ||
                         job_i.seq == sfcs_pkg::SEQ_REL_BLOCK) ? sfcs_pkg::CmdBe
                                                               : sfcs_pkg::CmdPp;
            4'd3: byt = a[23:16];
            4'd4: byt = a[15:8];
            4'd5: begin
              byt = a[7:0];
              fin = (job_i.seq == sfcs_pkg::SEQ_PAGE || job_i.seq == sfcs_pkg::SEQ_REL_PAGE);
            end
            4'd6: act = sfcs_pkg::ACT_REL;
            4'd7: byt = sfcs_pkg::CmdRdsr;
            default: begin
              act = sfcs_pkg::ACT_RX;
              fin = 1'b1;
            end
          endcase
        end
      end
      sfcs_pkg::SEQ_READ_RX, sfcs_pkg::SEQ_READ_POLL: begin
        unique case (step_q)
          4'd0: byt = sfcs_pkg::CmdRead;
          4'd1: byt = a[23:16];
          4'd2: byt = a[15:8];
          4'd3: byt = a[7:0];
          4'd4: begin
            if (job_i.seq == sfcs_pkg::SEQ_READ_RX) begin
              act = sfcs_pkg::ACT_RX;
              fin = 1'b1;
            end else begin
              act = sfcs_pkg::ACT_REL;
            end
          end
          4'd5: byt = sfcs_pkg::CmdRdsr;
          default: begin
            act = sfcs_pkg::ACT_RX;
            fin = 1'b1;
          end
        endcase
      end
      sfcs_pkg::SEQ_PROBE: begin
        unique case (step_q)
          4'd0: byt = sfcs_pkg::CmdRsten;
          4'd1: act = sfcs_pkg::ACT_REL;
          4'd2: byt = sfcs_pkg::CmdRst;
          4'd3: act = sfcs_pkg::ACT_REL;
          4'd4: byt = sfcs_pkg::CmdWrsr;
          4'd5: byt = 8'h00;
          4'd6: act = sfcs_pkg::ACT_REL;
          4'd7: byt = sfcs_pkg::CmdRdid;
          default: begin
            act = sfcs_pkg::ACT_RX;
            fin = 1'b1;
          end
        endcase
      end
      sfcs_pkg::SEQ_TX_ONLY, sfcs_pkg::SEQ_TX_POLL: begin
        unique case (step_q)
          4'd0: begin
            byt = job_i.data;
            fin = (job_i.seq == sfcs_pkg::SEQ_TX_ONLY);
          end
          4'd1: act = sfcs_pkg::ACT_REL;
          4'd2: byt = sfcs_pkg::CmdRdsr;
          default: begin
            act = sfcs_pkg::ACT_RX;
            fin = 1'b1;
          end
        endcase
      end
      sfcs_pkg::SEQ_HOST_RX, sfcs_pkg::SEQ_HOST_POLL: begin
        unique case (step_q)
          4'd0: begin
            act = sfcs_pkg::ACT_HOST;
            byt = job_i.data;
          end
          4'd1: begin
            if (job_i.seq == sfcs_pkg::SEQ_HOST_RX) begin
              act = sfcs_pkg::ACT_RX;
              fin = 1'b1;
            end else begin
              act = sfcs_pkg::ACT_REL;
            end
          end
          4'd2: byt = sfcs_pkg::CmdRdsr;
          default: begin
            act = sfcs_pkg::ACT_RX;
            fin = 1'b1;
          end
        endcase
      end
      sfcs_pkg::SEQ_RX: begin
        act = sfcs_pkg::ACT_RX;
        fin = 1'b1;
      end
      default: begin
        // Release then completion, with the ID on probe completion.
        if (step_q == 4'd0) begin
          act = sfcs_pkg::ACT_REL;
        end else begin
          act = sfcs_pkg::ACT_DONE;
          fin = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      step_q <= '0;
    end else begin
      if (load) begin
        vld_q  <= 1'b1;
        step_q <= fin ? 4'd0 : step_q + 4'd1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q  <= act;
      byte_q <= byt;
      id_q   <= (job_i.seq == sfcs_pkg::SEQ_REL_DONE_ID && fin) ? job_i.addr : 24'd0;
      flt_q  <= job_i.seq == sfcs_pkg::SEQ_FAULT;
      last_q <= fin;
    end
  end

  assign out_valid_o = vld_q;
  assign action_o    = act_q;
  assign bus_byte_o  = byte_q;
  assign device_id_o = id_q;
  assign fault_o     = flt_q;
  assign last_o      = last_q;
endmodule

// ===== design/spi_flash_command_sequencer_unit.sv =====
// Top level of the SPI flash command sequencer.
//
// The request channel (req_if) carries erase, write, read and probe requests, write
// data bytes and bytes received from the flash. The result channel (res_if) carries
// SPI bus actions: transmit a byte, clock in a byte, release chip select, hand a
// read byte to the host, or report completion with the device ID after a probe.
// Each request causes one to ten results; the last one has last set. A request
// that is not expected in the current phase is dropped and answered by a single
// release result with fault set.
// The front end classifies a request in the cycle it is accepted and pushes one job
// into a two-entry queue; the back end expands it into results at one per cycle
// while results are taken. Throughput is bounded by the back end, which frees a job
// from the queue only as it loads that job's last result. A stalled result channel
// holds the result register; the queue then fills and the request channel deasserts
// ready. Reset returns the sequencer to idle with an empty queue and no result
// pending.
module spi_flash_command_sequencer_unit #(
  parameter int unsigned PageBytes  = sfcs_pkg::PageBytesDef,
  parameter int unsigned EraseBytes = sfcs_pkg::EraseBytesDef
) (
  input logic clk_i,
  input logic rst_ni,
  sfcs_if.sink   req_if,
  sfcs_if.source res_if
);
  logic           fj_valid, fj_ready;
  sfcs_pkg::job_t fj;
  logic           bj_valid, bj_ready;
  sfcs_pkg::job_t bj;

  sfcs_front #(.PageBytes(PageBytes), .EraseBytes(EraseBytes)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (req_if.valid),
    .in_ready_o   (req_if.ready),
    .req_type_i   (req_if.payload.req_type),
    .flash_addr_i (req_if.payload.flash_addr),
    .span_i       (req_if.payload.span),
    .data_byte_i  (req_if.payload.data_byte),
    .job_valid_o  (fj_valid),
    .job_ready_i  (fj_ready),
    .job_o        (fj)
  );

  sfcs_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (fj_valid), .wr_ready_o (fj_ready), .wr_job_i (fj),
    .rd_valid_o (bj_valid), .rd_ready_i (bj_ready), .rd_job_o (bj)
  );

  sfcs_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid), .job_ready_o (bj_ready), .job_i (bj),
    .out_valid_o (res_if.valid), .out_ready_i (res_if.ready),
    .action_o    (res_if.payload.action),
    .bus_byte_o  (res_if.payload.bus_byte),
    .device_id_o (res_if.payload.device_id),
    .fault_o     (res_if.payload.fault),
    .last_o      (res_if.payload.last)
  );
endmodule

// ===== design/sfcs_checker.sv =====
// Port checker of the SPI flash command sequencer, bound to the top level.
module sfcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  action_i,
  input logic [23:0] device_id_i,
  input logic        fault_i,
  input logic        last_i
);
  a_fault_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && fault_i |-> last_i && action_i == sfcs_pkg::ACT_REL)
    else $error("fault result not final");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && action_i == sfcs_pkg::ACT_DONE |-> last_i)
    else $error("completion not final");
  a_id_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && device_id_i != 24'd0 |-> action_i == sfcs_pkg::ACT_DONE)
    else $error("id outside completion");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(action_i))
    else $error("result dropped");
endmodule

bind spi_flash_command_sequencer_unit sfcs_checker u_sfcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_if.valid),
  .res_ready_i (res_if.ready),
  .action_i    (res_if.payload.action),
  .device_id_i (res_if.payload.device_id),
  .fault_i     (res_if.payload.fault),
  .last_i      (res_if.payload.last)
);

// ===== dv/spi_flash_command_sequencer_unit_tb.sv =====
// Self-checking testbench for the SPI flash command sequencer top level.
module spi_flash_command_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PageSize   = sfcs_pkg::PageBytesDef;
  localparam int unsigned BlockSize  = sfcs_pkg::EraseBytesDef;
  localparam int unsigned RandomReqs = 435;
  localparam int unsigned DrainWait  = 30;

  // Codes that the request type field can carry but the package leaves unnamed.
  localparam logic [2:0] ReqBad6 = 3'd6;
  localparam logic [2:0] ReqBad7 = 3'd7;

  logic clk_i;
  logic rst_ni;

  sfcs_if #(.payload_t(sfcs_pkg::req_t)) req_if ();
  sfcs_if #(.payload_t(sfcs_pkg::res_t)) res_if ();

  spi_flash_command_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .res_if (res_if)
  );

  // The clock runs with a 12 ns period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow state of the sequencer, updated as each request is accepted.
  sfcs_pkg::phase_e sh_phase;
  logic [2:0]  sh_op;
  logic [23:0] sh_addr;
  logic [24:0] sh_bytes_left;
  logic [8:0]  sh_page_left;
  logic [8:0]  sh_blocks_left;
  logic [23:0] sh_id;
  logic [1:0]  sh_id_idx;

  // Bus actions that the sequencer still owes, oldest first.
  sfcs_pkg::res_t pending_actions[$];

  int unsigned error_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void add_action(ref sfcs_pkg::res_t rs[$], input logic [2:0] act,
                                     input logic [7:0] b, input logic [23:0] id,
                                     input logic flt);
    sfcs_pkg::res_t r;
    r.action    = act;
    r.bus_byte  = b;
    r.device_id = id;
    r.fault     = flt;
    r.last      = 1'b0;
    rs.push_back(r);
  endfunction

  function automatic void add_tx_addr(ref sfcs_pkg::res_t rs[$], input logic [23:0] a);
    add_action(rs, sfcs_pkg::ACT_TX, a[23:16], '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_TX, a[15:8], '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_TX, a[7:0], '0, 1'b0);
  endfunction

  // Chip select is released, then status is read until the busy bit clears.
  function automatic void begin_busy_poll(ref sfcs_pkg::res_t rs[$]);
    add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdRdsr, '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_RX, '0, '0, 1'b0);
    sh_phase = sfcs_pkg::PH_POLL;
  endfunction

  function automatic void begin_erase_block(ref sfcs_pkg::res_t rs[$]);
    add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdWren, '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdBe, '0, 1'b0);
    add_tx_addr(rs, sh_addr);
    begin_busy_poll(rs);
  endfunction

  // A page program never crosses a page boundary.
  function automatic void begin_page(ref sfcs_pkg::res_t rs[$]);
    logic [24:0] room;
    room = PageSize - (sh_addr % PageSize);
    sh_page_left = (sh_bytes_left < room) ? sh_bytes_left[8:0] : room[8:0];
    add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdWren, '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
    add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdPp, '0, 1'b0);
    add_tx_addr(rs, sh_addr);
    sh_phase = sfcs_pkg::PH_WDATA;
  endfunction

  function automatic void finish_op(ref sfcs_pkg::res_t rs[$], input logic [23:0] id);
    add_action(rs, sfcs_pkg::ACT_DONE, '0, id, 1'b0);
    sh_phase = sfcs_pkg::PH_IDLE;
  endfunction

  // Works out the bus actions that one request causes and advances the shadow state.
  function automatic void sequence_actions(input sfcs_pkg::req_t q,
                                           ref sfcs_pkg::res_t rs[$]);
    logic ok;
    logic [24:0] range_len;
    ok = 1'b0;
    if (sh_phase == sfcs_pkg::PH_IDLE && q.req_type <= sfcs_pkg::REQ_PROBE) begin
      ok = 1'b1;
      sh_op = q.req_type;
      sh_addr = q.flash_addr;
      if (q.req_type == sfcs_pkg::REQ_ERASE) begin
        range_len = q.span - {1'b0, q.flash_addr};
        sh_blocks_left = (q.span > {1'b0, q.flash_addr}) ? 9'(range_len / BlockSize) : '0;
        if (sh_blocks_left != 0) begin
          begin_erase_block(rs);
        end else begin
          finish_op(rs, '0);
        end
      end else if (q.req_type == sfcs_pkg::REQ_WRITE) begin
        sh_bytes_left = q.span;
        if (sh_bytes_left != 0) begin
          begin_page(rs);
        end else begin
          finish_op(rs, '0);
        end
      end else if (q.req_type == sfcs_pkg::REQ_READ) begin
        sh_bytes_left = q.span;
        add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdRead, '0, 1'b0);
        add_tx_addr(rs, q.flash_addr);
        if (sh_bytes_left != 0) begin
          add_action(rs, sfcs_pkg::ACT_RX, '0, '0, 1'b0);
          sh_phase = sfcs_pkg::PH_RDATA;
        end else begin
          begin_busy_poll(rs);
        end
      end else begin
        // Probe: reset enable, reset, status write of zero, then read ID.
        sh_id = '0;
        sh_id_idx = '0;
        add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdRsten, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdRst, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdWrsr, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_TX, 8'h00, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_TX, sfcs_pkg::CmdRdid, '0, 1'b0);
        add_action(rs, sfcs_pkg::ACT_RX, '0, '0, 1'b0);
        sh_phase = sfcs_pkg::PH_ID;
      end
    end else if (sh_phase == sfcs_pkg::PH_WDATA && q.req_type == sfcs_pkg::REQ_WDATA) begin
      ok = 1'b1;
      add_action(rs, sfcs_pkg::ACT_TX, q.data_byte, '0, 1'b0);
      sh_addr = sh_addr + 24'd1;
      sh_bytes_left = sh_bytes_left - 25'd1;
      sh_page_left = sh_page_left - 9'd1;
      if (sh_page_left == 0) begin_busy_poll(rs);
    end else if (sh_phase == sfcs_pkg::PH_RDATA && q.req_type == sfcs_pkg::REQ_RXB) begin
      ok = 1'b1;
      add_action(rs, sfcs_pkg::ACT_HOST, q.data_byte, '0, 1'b0);
      sh_bytes_left = sh_bytes_left - 25'd1;
      if (sh_bytes_left != 0) begin
        add_action(rs, sfcs_pkg::ACT_RX, '0, '0, 1'b0);
      end else begin
        begin_busy_poll(rs);
      end
    end else if (sh_phase == sfcs_pkg::PH_POLL && q.req_type == sfcs_pkg::REQ_RXB) begin
      ok = 1'b1;
      if (q.data_byte[0]) begin
        add_action(rs, sfcs_pkg::ACT_RX, '0, '0, 1'b0);
      end else begin
        add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
        if (sh_op == sfcs_pkg::REQ_ERASE) begin
          sh_blocks_left = sh_blocks_left - 9'd1;
          sh_addr = sh_addr + 24'(BlockSize);
          if (sh_blocks_left != 0) begin
            begin_erase_block(rs);
          end else begin
            finish_op(rs, '0);
          end
        end else if (sh_op == sfcs_pkg::REQ_WRITE && sh_bytes_left != 0) begin
          begin_page(rs);
        end else begin
          finish_op(rs, '0);
        end
      end
    end else if (sh_phase == sfcs_pkg::PH_ID && q.req_type == sfcs_pkg::REQ_RXB) begin
      ok = 1'b1;
      sh_id = sh_id | (24'(q.data_byte) << (8 * sh_id_idx));
      sh_id_idx = sh_id_idx + 2'd1;
      if (sh_id_idx == 2'd3) begin
        add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b0);
        finish_op(rs, sh_id);
        sh_id_idx = '0;
      end else begin
        add_action(rs, sfcs_pkg::ACT_RX, '0, '0, 1'b0);
      end
    end
    if (!ok) add_action(rs, sfcs_pkg::ACT_REL, '0, '0, 1'b1);
    rs[rs.size() - 1].last = 1'b1;
  endfunction

  // Offers one request and waits for it to be taken. A typed-in result, where given,
  // stands in for the computed one; the shadow state still advances.
  task automatic send_request(input sfcs_pkg::req_t q, input logic typed,
                              input logic [2:0] t_act, input logic [23:0] t_id,
                              input logic t_flt);
    sfcs_pkg::res_t rs[$];
    sfcs_pkg::res_t t;
    req_if.valid   <= 1'b1;
    req_if.payload <= q;
    do @(posedge clk_i); while (!req_if.ready);
    sequence_actions(q, rs);
    if (typed) begin
      t = '{action: t_act, bus_byte: '0, device_id: t_id, fault: t_flt, last: 1'b1};
      pending_actions.push_back(t);
    end else begin
      foreach (rs[i]) pending_actions.push_back(rs[i]);
    end
    if ($urandom_range(0, 99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // The result side: ready is redrawn each cycle and every result is checked.
  always @(posedge clk_i) begin
    sfcs_pkg::res_t got;
    sfcs_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_actions.size() == 0) begin
        report_mismatch("unexpected result action", 32'(got.action), '0);
      end else begin
        want = pending_actions.pop_front();
        if (got.action !== want.action)
          report_mismatch("action", 32'(got.action), 32'(want.action));
        if (got.bus_byte !== want.bus_byte)
          report_mismatch("bus_byte", 32'(got.bus_byte), 32'(want.bus_byte));
        if (got.device_id !== want.device_id)
          report_mismatch("device_id", 32'(got.device_id), 32'(want.device_id));
        if (got.fault !== want.fault)
          report_mismatch("fault", 32'(got.fault), 32'(want.fault));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
    res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  typedef struct {
    logic [2:0]  req;
    logic [23:0] addr;
    logic [24:0] span;
    logic [7:0]  data;
    logic        typed;
    logic [2:0]  t_act;
    logic [23:0] t_id;
    logic        t_flt;
  } step_t;

  // The directed part covers the special cases: items that are not awaited, empty
  // ranges, address wrap at the top of the array, a status poll that repeats after busy,
  // a page split, and a request that arrives while an operation is running.
  localparam int unsigned NumSteps = 25;
  step_t steps [NumSteps] = '{
    '{sfcs_pkg::REQ_WDATA, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 1'b1, sfcs_pkg::ACT_REL, 24'h0, 1'b1},
    '{ReqBad7, 24'h0, 25'h0, 8'h00, 1'b1, sfcs_pkg::ACT_REL, 24'h0, 1'b1},
    '{ReqBad6, 24'h0, 25'h0, 8'h00, 1'b1, sfcs_pkg::ACT_REL, 24'h0, 1'b1},
    '{sfcs_pkg::REQ_ERASE, 24'h0, 25'h0, 8'h00, 1'b1, sfcs_pkg::ACT_DONE, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_ERASE, 24'hFFFFFF, 25'h1000000, 8'h00, 1'b1, sfcs_pkg::ACT_DONE, 24'h0,
      1'b0},
    '{sfcs_pkg::REQ_ERASE, 24'hFF0010, 25'h1000010, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h01, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'hFE, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_WRITE, 24'hFFFFFE, 25'h3, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_WDATA, 24'h0, 25'h0, 8'hFF, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_WDATA, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_PROBE, 24'h0, 25'h0, 8'h00, 1'b1, sfcs_pkg::ACT_REL, 24'h0, 1'b1},
    '{sfcs_pkg::REQ_WDATA, 24'h0, 25'h0, 8'hA5, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_WRITE, 24'h123456, 25'h0, 8'h00, 1'b1, sfcs_pkg::ACT_DONE, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_READ, 24'hFFFFFF, 25'h1, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'hFF, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_READ, 24'h000000, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_PROBE, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'hFF, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h00, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0},
    '{sfcs_pkg::REQ_RXB, 24'h0, 25'h0, 8'h5A, 1'b0, sfcs_pkg::ACT_TX, 24'h0, 1'b0}
  };

  // Builds one random request. Mostly it is the item the sequencer waits for, with
  // random content; the rest is noise, dropped with a fault unless it happens to fit.
  function automatic sfcs_pkg::req_t random_request();
    sfcs_pkg::req_t q;
    int unsigned k;
    q.req_type   = 3'($urandom_range(0, 7));
    q.flash_addr = 24'($urandom());
    q.span       = 25'($urandom());
    q.data_byte  = 8'($urandom());
    k = $urandom_range(0, 99);
    if (k < 12) return q;
    if (sh_phase == sfcs_pkg::PH_IDLE) begin
      q.req_type = 3'($urandom_range(sfcs_pkg::REQ_ERASE, sfcs_pkg::REQ_PROBE));
      case (q.req_type)
        sfcs_pkg::REQ_ERASE: begin
          q.span = {1'b0, q.flash_addr} + 25'($urandom_range(0, 3) * BlockSize)
                   + 25'($urandom_range(0, BlockSize - 1));
        end
        sfcs_pkg::REQ_WRITE: begin
          q.span = ($urandom_range(0, 19) == 0) ? 25'($urandom_range(200, 600))
                                                : 25'($urandom_range(0, 20));
        end
        sfcs_pkg::REQ_READ: begin
          q.span = 25'($urandom_range(0, 6));
        end
        default: ;
      endcase
    end else if (sh_phase == sfcs_pkg::PH_WDATA) begin
      q.req_type = sfcs_pkg::REQ_WDATA;
    end else begin
      q.req_type = sfcs_pkg::REQ_RXB;
      if (sh_phase == sfcs_pkg::PH_POLL) q.data_byte[0] = ($urandom_range(0, 99) < 30);
    end
    return q;
  endfunction

  initial begin
    int unsigned accepted;
    bit paused;
    sfcs_pkg::req_t q;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    res_if.ready   = 1'b0;
    error_count    = 0;
    send_gap_pct   = 16;
    recv_stall_pct = 65;
    sh_phase       = sfcs_pkg::PH_IDLE;
    sh_op          = sfcs_pkg::REQ_ERASE;
    sh_addr        = '0;
    sh_bytes_left  = '0;
    sh_page_left   = '0;
    sh_blocks_left = '0;
    sh_id          = '0;
    sh_id_idx      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      q = '{steps[i].req, steps[i].addr, steps[i].span, steps[i].data};
      send_request(q, steps[i].typed, steps[i].t_act, steps[i].t_id, steps[i].t_flt);
    end

    accepted = 0;
    paused = 0;
    while (accepted < RandomReqs) begin
      // Swap the idle rates after the first third, and stop idling for the last.
      if (accepted == RandomReqs / 3) begin
        send_gap_pct = 65;
        recv_stall_pct = 16;
      end else if (accepted == 2 * RandomReqs / 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      // Once, hold the sender back until the result side has drained completely.
      if (!paused && accepted == RandomReqs / 2) begin
        paused = 1;
        req_if.valid <= 1'b0;
        wait (pending_actions.size() == 0);
        @(posedge clk_i);
      end
      send_request(random_request(), 1'b0, sfcs_pkg::ACT_TX, '0, 1'b0);
      accepted++;
    end
    req_if.valid <= 1'b0;

    wait (pending_actions.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0 && pending_actions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
